[rtl/rpa_pkg.sv]
package rpa_pkg;

	// default sizing of the pool
	localparam int NUM_REGS_DEF    = 14;
	localparam int FIRST_ALLOC_DEF = 3;
	localparam int TAG_WIDTH_DEF   = 8;

	// owner slots that take a record
	localparam int RECORD_SLOTS = 2;

	typedef enum logic [1:0] {
		ACT_ALLOC     = 2'd0,
		ACT_FREE      = 2'd1,
		ACT_FREE_TEMP = 2'd2,
		ACT_QUERY     = 2'd3
	} rpa_action_t;

	typedef struct packed {
		rpa_action_t action;
		logic [3:0]  reg_number;
		logic        owner_present;
		logic [7:0]  owner_tag;
		logic [1:0]  owner_slot;
	} rpa_req_t;

	typedef struct packed {
		logic [3:0] reg_out;
		logic       is_owned;
		logic       record_valid;
		logic       record_slot;
		logic       released_valid;
		logic [7:0] released_owner;
		logic [3:0] released_reg;
	} rpa_rsp_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic pick;
		logic apply;
	} rpa_cmd_t;

endpackage

[rtl/rpa_ctrl.sv]
module rpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output rpa_pkg::rpa_cmd_t cmd
);
	import rpa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PICK  = 3'b010,
		ST_APPLY = 3'b100
	} rpa_state_t;

	rpa_state_t state_q, state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_PICK;
			ST_PICK:  state_d = ST_APPLY;
			ST_APPLY: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_APPLY);
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign cmd.load  = (state_q == ST_IDLE) && start;
	assign cmd.pick  = (state_q == ST_PICK);
	assign cmd.apply = (state_q == ST_APPLY);

endmodule

[rtl/rpa_datapath.sv]
module rpa_datapath #(
	parameter int NUM_REGS    = rpa_pkg::NUM_REGS_DEF,
	parameter int FIRST_ALLOC = rpa_pkg::FIRST_ALLOC_DEF,
	parameter int TAG_WIDTH   = rpa_pkg::TAG_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rpa_pkg::rpa_cmd_t cmd,
	input  rpa_pkg::rpa_req_t req,
	output rpa_pkg::rpa_rsp_t result
);
	import rpa_pkg::*;

	localparam int IW = $clog2(NUM_REGS);
	localparam bit POOL_EMPTY = (FIRST_ALLOC >= NUM_REGS);
	localparam logic [6:0] FIRST_W = 7'(FIRST_ALLOC);
	localparam logic [6:0] LIMIT_W = 7'(NUM_REGS);
	localparam logic [IW-1:0] FIRST_IDX = IW'(FIRST_ALLOC);
	localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_REGS - 1);

	rpa_req_t               req_q;
	logic [NUM_REGS-1:0]    busy_bits_q;
	logic [NUM_REGS-1:0]    tag_valid_q;
	logic [IW-1:0]          victim_q;
	logic [TAG_WIDTH-1:0]   tag_mem [NUM_REGS];
	rpa_rsp_t               result_q;

	// pick stage results
	logic [IW-1:0]          tgt_s1;
	logic                   ok_s1;
	logic                   evict_s1;
	logic [TAG_WIDTH-1:0]   rd_tag_s1;

	// pick stage logic
	logic                   free_found;
	logic [IW-1:0]          free_idx;
	logic                   in_pool;
	logic                   is_alloc;
	logic [IW-1:0]          pick_tgt;
	logic                   pick_ok;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_REGS - 1; i >= FIRST_ALLOC; i--) begin
			if (!busy_bits_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign is_alloc = (req_q.action == ACT_ALLOC);
	assign in_pool  = ({3'b000, req_q.reg_number} >= FIRST_W) &&
	                  ({3'b000, req_q.reg_number} < LIMIT_W);

	always_comb begin
		if (is_alloc) begin
			pick_ok  = !POOL_EMPTY;
			pick_tgt = free_found ? free_idx : victim_q;
		end else begin
			pick_ok  = in_pool;
			pick_tgt = in_pool ? IW'(req_q.reg_number) : '0;
		end
		if (!pick_ok) pick_tgt = '0;
	end

	// apply stage logic
	logic busy_t, owned_t;
	logic alloc_go, free_go, temp_go, query_go;
	logic do_release;
	rpa_rsp_t rsp_d;

	assign busy_t   = busy_bits_q[tgt_s1];
	assign owned_t  = tag_valid_q[tgt_s1];
	assign alloc_go = ok_s1 && (req_q.action == ACT_ALLOC);
	assign free_go  = ok_s1 && (req_q.action == ACT_FREE);
	assign temp_go  = ok_s1 && (req_q.action == ACT_FREE_TEMP);
	assign query_go = ok_s1 && (req_q.action == ACT_QUERY);
	// eviction or free of an owned, busy register reports the owner
	assign do_release = ((alloc_go && evict_s1) || free_go) && busy_t && owned_t;

	always_comb begin
		rsp_d = '0;
		rsp_d.reg_out = req_q.reg_number;
		if (req_q.action == ACT_ALLOC) begin
			rsp_d.reg_out = alloc_go ? 4'(tgt_s1) : 4'd0;
		end
		if (alloc_go && req_q.owner_present &&
		    ({30'd0, req_q.owner_slot} < 32'(RECORD_SLOTS))) begin
			rsp_d.record_valid = 1'b1;
			rsp_d.record_slot  = req_q.owner_slot[0];
		end
		if (query_go) rsp_d.is_owned = owned_t;
		if (do_release) begin
			rsp_d.released_valid = 1'b1;
			rsp_d.released_owner = 8'(rd_tag_s1);
			rsp_d.released_reg   = 4'(tgt_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.pick) begin
			tgt_s1   <= pick_tgt;
			ok_s1    <= pick_ok;
			evict_s1 <= !free_found;
		end
		if (cmd.apply) result_q <= rsp_d;
	end

	// tag memory: read in pick, written in apply
	always_ff @(posedge clk) begin
		if (cmd.pick) rd_tag_s1 <= tag_mem[pick_tgt];
		if (alloc_go && cmd.apply && req_q.owner_present)
			tag_mem[tgt_s1] <= TAG_WIDTH'(req_q.owner_tag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_bits_q <= '0;
			tag_valid_q <= '0;
			victim_q    <= FIRST_IDX;
		end else if (cmd.apply) begin
			if (alloc_go) begin
				busy_bits_q[tgt_s1] <= 1'b1;
				tag_valid_q[tgt_s1] <= req_q.owner_present;
				if (evict_s1) victim_q <= (victim_q == LAST_IDX) ? FIRST_IDX : victim_q + 1'b1;
			end
			if (free_go && busy_t) begin
				busy_bits_q[tgt_s1] <= 1'b0;
				tag_valid_q[tgt_s1] <= 1'b0;
			end
			if (temp_go && !owned_t) busy_bits_q[tgt_s1] <= 1'b0;
		end
	end

	assign result = result_q;

endmodule

[rtl/register_pool_allocator_core.sv]
// register pool allocator: hands out registers FIRST_ALLOC..NUM_REGS-1, lowest free
// first, evicting round-robin when the pool is full. a request transfer happens
// on a clock edge with start high and busy low, and the request is latched on that
// edge; busy then stays high in the pick state (tag memory read and pick) and the
// apply state (update), taking no new request before the update. the result is
// marked by done, high for exactly one cycle, in the first cycle with busy low
// again; the receiver cannot stall it, so it must take every result in that cycle.
// a new request may be started in the same cycle that done is high.
module register_pool_allocator_core #(
	parameter int NUM_REGS    = rpa_pkg::NUM_REGS_DEF,
	parameter int FIRST_ALLOC = rpa_pkg::FIRST_ALLOC_DEF,
	parameter int TAG_WIDTH   = rpa_pkg::TAG_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rpa_pkg::rpa_req_t req,
	output logic              done,
	output rpa_pkg::rpa_rsp_t result
);
	import rpa_pkg::*;

	// command bundle from the sequencer
	rpa_cmd_t cmd;

	// sequencer: idle, pick target, apply update
	rpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// busy and owner bits, tag memory, victim pointer and result register
	rpa_datapath #(
		.NUM_REGS    (NUM_REGS),
		.FIRST_ALLOC (FIRST_ALLOC),
		.TAG_WIDTH   (TAG_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.result (result)
	);

endmodule

[sim/register_pool_allocator_core_tb.sv]
module register_pool_allocator_core_tb;
	import rpa_pkg::*;

	// pool geometry as built by the default instance
	localparam int POOL_END   = NUM_REGS_DEF;
	localparam int POOL_FIRST = FIRST_ALLOC_DEF;

	// settle time after the last result, and the run limit in time units
	localparam int TAIL_CYCLES = 12;
	localparam int RUN_LIMIT   = 2_000_000;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	rpa_req_t req;
	logic     done;
	rpa_rsp_t result;

	// mirror of the pool: busy bit, owner valid, owner tag, eviction pointer
	bit       reg_taken   [POOL_END];
	bit       owner_known [POOL_END];
	bit [7:0] owner_of    [POOL_END];
	int       evict_ptr;

	// predicted responses, oldest first
	rpa_rsp_t pending_rsp[$];
	rpa_rsp_t oldest_rsp;

	int err_count;
	int sender_idle_pct;

	register_pool_allocator_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// run limit, far beyond the slowest legal run
	initial begin
		#RUN_LIMIT;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		err_count++;
	endtask

	// give back a busy register; an owned one names its owner in the response
	function automatic void drop_entry(input int r, inout rpa_rsp_t rs);
		if (reg_taken[r]) begin
			reg_taken[r] = 1'b0;
			if (owner_known[r]) begin
				rs.released_valid = 1'b1;
				rs.released_owner = owner_of[r];
				rs.released_reg   = r[3:0];
				owner_known[r]    = 1'b0;
			end
		end
	endfunction

	// apply one request to the mirror and return the response it must produce
	function automatic rpa_rsp_t pool_step(input rpa_req_t rq);
		rpa_rsp_t rs;
		int       r;
		int       i;
		bit       found;
		bit       in_pool;
		rs      = '0;
		rs.reg_out = rq.reg_number;
		found   = 1'b0;
		r       = POOL_FIRST;
		in_pool = (rq.reg_number >= POOL_FIRST) && (rq.reg_number < POOL_END);
		case (rq.action)
			ACT_ALLOC: begin
				// lowest free register wins
				for (i = POOL_FIRST; i < POOL_END; i++) begin
					if (!found && !reg_taken[i]) begin
						r     = i;
						found = 1'b1;
					end
				end
				// full pool: evict at the round-robin pointer, then advance it
				if (!found) begin
					if (evict_ptr < POOL_FIRST || evict_ptr >= POOL_END)
						evict_ptr = POOL_FIRST;
					r = evict_ptr;
					drop_entry(r, rs);
					evict_ptr++;
					if (evict_ptr >= POOL_END)
						evict_ptr = POOL_FIRST;
				end
				reg_taken[r]   = 1'b1;
				owner_known[r] = rq.owner_present;
				if (rq.owner_present)
					owner_of[r] = rq.owner_tag;
				rs.reg_out = r[3:0];
				// only the low slots take a record, the tag is kept either way
				if (rq.owner_present && rq.owner_slot < RECORD_SLOTS) begin
					rs.record_valid = 1'b1;
					rs.record_slot  = rq.owner_slot[0];
				end
			end
			ACT_FREE: begin
				if (in_pool)
					drop_entry(rq.reg_number, rs);
			end
			ACT_FREE_TEMP: begin
				// an owned register survives a temporary free
				if (in_pool && !owner_known[rq.reg_number])
					reg_taken[rq.reg_number] = 1'b0;
			end
			default: begin
				if (in_pool && owner_known[rq.reg_number])
					rs.is_owned = 1'b1;
			end
		endcase
		return rs;
	endfunction

	// one request transfer: optional idle cycles, then hold start until taken
	task automatic send_request(input rpa_req_t rq);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req   <= rq;
		// busy seen here is its value before the edge, so this is the taking edge
		do
			@(posedge clk);
		while (busy);
		pending_rsp.push_back(pool_step(rq));
	endtask

	task automatic go_quiet();
		@(negedge clk);
		start <= 1'b0;
	endtask

	function automatic rpa_req_t make_req(input rpa_action_t act, input int regn,
		input bit owned, input int tag, input int slot);
		rpa_req_t rq;
		rq.action        = act;
		rq.reg_number    = regn[3:0];
		rq.owner_present = owned;
		rq.owner_tag     = tag[7:0];
		rq.owner_slot    = slot[1:0];
		return rq;
	endfunction

	// result checker: every done cycle must match the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("result with no request pending", 1, 0);
			end else begin
				oldest_rsp = pending_rsp.pop_front();
				if (result.reg_out !== oldest_rsp.reg_out)
					report_mismatch("reg_out", result.reg_out, oldest_rsp.reg_out);
				if (result.is_owned !== oldest_rsp.is_owned)
					report_mismatch("is_owned", result.is_owned, oldest_rsp.is_owned);
				if (result.record_valid !== oldest_rsp.record_valid)
					report_mismatch("record_valid", result.record_valid,
						oldest_rsp.record_valid);
				if (result.record_slot !== oldest_rsp.record_slot)
					report_mismatch("record_slot", result.record_slot,
						oldest_rsp.record_slot);
				if (result.released_valid !== oldest_rsp.released_valid)
					report_mismatch("released_valid", result.released_valid,
						oldest_rsp.released_valid);
				if (result.released_owner !== oldest_rsp.released_owner)
					report_mismatch("released_owner", result.released_owner,
						oldest_rsp.released_owner);
				if (result.released_reg !== oldest_rsp.released_reg)
					report_mismatch("released_reg", result.released_reg,
						oldest_rsp.released_reg);
			end
		end
	end

	// allocation from an empty pool, covering every slot code and tag extremes
	task automatic test_allocate();
		send_request(make_req(ACT_ALLOC, 0, 1'b1, 8'h00, 0));
		send_request(make_req(ACT_ALLOC, 15, 1'b1, 8'hFF, 1));
		// owner without a slot: tag kept, no record
		send_request(make_req(ACT_ALLOC, 9, 1'b1, 8'hA5, 2));
		send_request(make_req(ACT_ALLOC, 6, 1'b1, 8'h5A, 3));
		// ownerless allocation
		send_request(make_req(ACT_ALLOC, 3, 1'b0, 8'hFF, 0));
	endtask

	// ownership queries in range and out of range
	task automatic test_query();
		send_request(make_req(ACT_QUERY, 3, 1'b0, 0, 0));
		send_request(make_req(ACT_QUERY, 7, 1'b1, 8'hFF, 3));
		send_request(make_req(ACT_QUERY, 8, 1'b0, 0, 0));
		send_request(make_req(ACT_QUERY, 0, 1'b0, 0, 0));
		send_request(make_req(ACT_QUERY, 14, 1'b0, 0, 0));
		send_request(make_req(ACT_QUERY, 15, 1'b0, 0, 0));
	endtask

	// free and temporary free, including the ignored and out-of-range cases
	task automatic test_release();
		// temporary free of an owned register leaves it busy
		send_request(make_req(ACT_FREE_TEMP, 4, 1'b0, 0, 0));
		send_request(make_req(ACT_FREE_TEMP, 7, 1'b0, 0, 0));
		send_request(make_req(ACT_FREE, 3, 1'b0, 0, 0));
		// freeing a register that is already free reports nothing
		send_request(make_req(ACT_FREE, 3, 1'b1, 8'hFF, 1));
		send_request(make_req(ACT_FREE, 15, 1'b0, 0, 0));
		send_request(make_req(ACT_FREE_TEMP, 1, 1'b0, 0, 0));
	endtask

	// fill the pool, then evict an ownerless register and then an owned one
	task automatic test_evict();
		int i;
		for (i = 0; i < 8; i++)
			send_request(make_req(ACT_ALLOC, i, i != 0, $urandom_range(255), i % 4));
		send_request(make_req(ACT_ALLOC, 0, 1'b1, 8'h3C, 0));
		send_request(make_req(ACT_ALLOC, 0, 1'b1, 8'hC3, 1));
	endtask

	function automatic rpa_req_t random_request(input int alloc_weight);
		rpa_req_t    rq;
		rpa_action_t act;
		int          pick;
		pick = $urandom_range(99);
		if (pick < alloc_weight)
			act = ACT_ALLOC;
		else
			case ($urandom_range(2))
				0:       act = ACT_FREE;
				1:       act = ACT_FREE_TEMP;
				default: act = ACT_QUERY;
			endcase
		rq.action = act;
		// mostly registers of the pool, sometimes any code at all
		if ($urandom_range(99) < 85)
			rq.reg_number = 4'($urandom_range(POOL_END - 1, POOL_FIRST));
		else
			rq.reg_number = 4'($urandom_range(15));
		rq.owner_present = ($urandom_range(99) < 70);
		rq.owner_tag     = 8'($urandom_range(255));
		rq.owner_slot    = 2'($urandom_range(3));
		return rq;
	endfunction

	// random traffic; the allocate share swings so the pool fills and drains
	task automatic test_random(input int n_items, input int idle_pct);
		int i;
		int alloc_weight;
		sender_idle_pct = idle_pct;
		alloc_weight    = 40;
		for (i = 0; i < n_items; i++) begin
			if (i % 64 == 0)
				case ($urandom_range(2))
					0:       alloc_weight = 20;
					1:       alloc_weight = 45;
					default: alloc_weight = 75;
				endcase
			send_request(random_request(alloc_weight));
		end
		go_quiet();
	endtask

	initial begin
		int i;
		arst_n          = 1'b0;
		start           = 1'b0;
		req             = '0;
		err_count       = 0;
		sender_idle_pct = 37;
		evict_ptr       = POOL_FIRST;
		for (i = 0; i < POOL_END; i++) begin
			reg_taken[i]   = 1'b0;
			owner_known[i] = 1'b0;
			owner_of[i]    = '0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_allocate();
		test_query();
		test_release();
		test_evict();
		go_quiet();

		// sender pacing: light idling, heavy idling, then back to back
		test_random(530, 37);
		test_random(530, 74);
		test_random(530, 0);

		// drain outstanding responses, then let the block settle
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/rpa_pkg.sv
rtl/rpa_ctrl.sv
rtl/rpa_datapath.sv
rtl/register_pool_allocator_core.sv
sim/register_pool_allocator_core_tb.sv
